// ===== design/tsw_pkg.sv =====
// Shared types, register indexes and the pixel deletion function of the
// thinning sub-pass window. No dependencies.
package tsw_pkg;

   // Configuration register layout
   localparam int CFG_W = 13;
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_SUB_PASS     = 2'd2;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [CFG_W-1:0] MIN_DIM      = 13'd3;

   // Per-beat control decoded from the raster position at accept time
   typedef struct packed {
      logic inb;       // pixel value that enters the image (0 outside / flush)
      logic mid_en;    // middle line store holds a row of this frame
      logic top_en;    // upper line store holds a row of this frame
      logic col_zero;  // first column of a row
      logic emit;      // this beat produces a result
      logic last_px;   // this beat produces the final result of the frame
   } step_type;

   // Line store write strobe and data
   typedef struct packed {
      logic we;
      logic mid;       // new pixel into the middle line
      logic upper;     // old middle entry into the upper line
   } ram_wr_type;

   // Window bit (col, row) sits at w[col*3+row]; col 0 is left, row 0 is top.
   // A set centre pixel is deleted when it has 2..6 set neighbors, exactly
   // one 0-to-1 transition around the ring and the sub-pass condition holds.
   function automatic logic delete_decision(logic [8:0] w, logic pass);
      logic [7:0] ring;
      logic [3:0] total;
      logic [3:0] trans;
      logic       cond;
      ring  = {w[0], w[1], w[2], w[5], w[8], w[7], w[6], w[3]};
      total = '0;
      trans = '0;
      for (int k = 0; k < 8; k++) begin
         total = total + {3'b000, ring[k]};
         trans = trans + {3'b000, ring[k] ^ ring[(k + 1) & 7]};
      end
      // ring: 0 N, 1 NE, 2 E, 3 SE, 4 S, 5 SW, 6 W, 7 NW
      if (pass) begin
         cond = !ring[2] || !ring[4] || (!ring[0] && !ring[6]);
      end else begin
         cond = !ring[0] || !ring[6] || (!ring[2] && !ring[4]);
      end
      return w[4] && (total >= 4'd2) && (total <= 4'd6) && (trans == 4'd2) && cond;
   endfunction

endpackage

// ===== design/tsw_if.sv =====
// Valid/ready stream interfaces for the pixel request and result channels.
// No dependencies.
interface tsw_req_if;
   logic valid;
   logic ready;
   logic pixel;
   logic flush;
   modport source (output valid, output pixel, output flush, input ready);
   modport sink   (input valid, input pixel, input flush, output ready);
endinterface

interface tsw_rsp_if;
   logic valid;
   logic ready;
   logic thinned_pixel;
   logic removed;
   logic last;
   logic any_removed;
   modport source (output valid, output thinned_pixel, output removed, output last,
                   output any_removed, input ready);
   modport sink   (input valid, input thinned_pixel, input removed, input last,
                   input any_removed, output ready);
endinterface

// ===== design/thinning_subpass_window.sv =====
// Top level of the thinning sub-pass window: scan counters, two line store
// RAMs and the working stage. Depends on tsw_pkg, tsw_if, tsw_ram, tsw_scan, tsw_window.
//
//   channel  | direction | handshake     | payload
//   ---------+-----------+---------------+------------------------------------------
//   req_bus  | in        | valid/ready   | pixel, flush
//   rsp_bus  | out       | valid/ready   | thinned_pixel, removed, last, any_removed
//   csr_*    | in        | write enable  | csr_index, csr_wdata (13 bits)
//
// One beat per clock sustained while rsp_bus is ready; a beat passes the working
// stage, then the result register; results lag one line plus one pixel once primed.
// The line store read is issued on accept and the write-back done as the beat
// leaves the working stage. Synchronous active-high reset clears counters,
// window and flags; line stores are not cleared. A stalled result holds the
// stage, and req_bus.ready drops only when both stage and result register are full.
module thinning_subpass_window #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   tsw_req_if.sink                   req_bus,
   tsw_rsp_if.source                 rsp_bus,
   input  logic                      csr_write_en,
   input  logic [1:0]                csr_index,
   input  logic [tsw_pkg::CFG_W-1:0] csr_wdata
);
   import tsw_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic             accept;
   logic             stage_ready;
   step_type         step;
   logic [COL_W-1:0] col;
   logic             sub_pass;
   logic             restart;
   logic             mid_raw;
   logic             top_raw;
   ram_wr_type       ram_wr;
   logic [COL_W-1:0] ram_waddr;

   assign accept        = req_bus.valid && stage_ready;
   assign req_bus.ready = stage_ready;

   // Registers and raster position
   tsw_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .pixel        (req_bus.pixel),
      .flush        (req_bus.flush),
      .step         (step),
      .col          (col),
      .sub_pass     (sub_pass),
      .restart      (restart)
   );

   // Previous row
   tsw_ram #(
      .WIDTH (1),
      .DEPTH (MAX_WIDTH)
   ) u_middle_line (
      .clock (clock),
      .we    (ram_wr.we),
      .waddr (ram_waddr),
      .wdata (ram_wr.mid),
      .re    (accept),
      .raddr (col),
      .rdata (mid_raw)
   );

   // Row before the previous one
   tsw_ram #(
      .WIDTH (1),
      .DEPTH (MAX_WIDTH)
   ) u_upper_line (
      .clock (clock),
      .we    (ram_wr.we),
      .waddr (ram_waddr),
      .wdata (ram_wr.upper),
      .re    (accept),
      .raddr (col),
      .rdata (top_raw)
   );

   // Window, decision and result register
   tsw_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .step_in   (step),
      .col_in    (col),
      .restart   (restart),
      .sub_pass  (sub_pass),
      .mid_raw   (mid_raw),
      .top_raw   (top_raw),
      .ready     (stage_ready),
      .ram_wr    (ram_wr),
      .ram_waddr (ram_waddr),
      .rsp       (rsp_bus)
   );

endmodule

// ===== design/tsw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module tsw_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/tsw_scan.sv =====
// Configuration registers and raster position counters; decodes each
// accepted beat into border and timing control. Depends on tsw_pkg.
module tsw_scan #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [1:0]                   csr_index,
   input  logic [tsw_pkg::CFG_W-1:0]    csr_wdata,
   input  logic                         accept,
   input  logic                         pixel,
   input  logic                         flush,
   output tsw_pkg::step_type            step,
   output logic [$clog2(MAX_WIDTH)-1:0] col,
   output logic                         sub_pass,
   output logic                         restart
);
   import tsw_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WD_W  = $clog2(MAX_WIDTH + 1);
   localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

   function automatic logic [WD_W-1:0] clamp_width(logic [CFG_W-1:0] v);
      logic [WD_W-1:0] r;
      if (v < MIN_DIM) begin
         r = WD_W'(MIN_DIM);
      end else if (int'(v) > MAX_WIDTH) begin
         r = WD_W'(MAX_WIDTH);
      end else begin
         r = WD_W'(v);
      end
      return r;
   endfunction

   function automatic logic [HT_W-1:0] clamp_height(logic [CFG_W-1:0] v);
      logic [HT_W-1:0] r;
      if (v < MIN_DIM) begin
         r = HT_W'(MIN_DIM);
      end else if (int'(v) > MAX_HEIGHT) begin
         r = HT_W'(MAX_HEIGHT);
      end else begin
         r = HT_W'(v);
      end
      return r;
   endfunction

   logic [WD_W-1:0]  width_ff,  width_in;
   logic [HT_W-1:0]  height_ff, height_in;
   logic             pass_ff,   pass_in;
   logic [COL_W-1:0] col_ff,    col_in;
   logic [ROW_W-1:0] row_ff,    row_in;

   logic             cfg_hit;
   logic [COL_W-1:0] col_max;
   logic [ROW_W-1:0] ht_row;
   logic [ROW_W-1:0] ht_row_p1;
   logic             end_px;

   assign cfg_hit = csr_write_en &&
                    (csr_index == REG_IMAGE_WIDTH || csr_index == REG_IMAGE_HEIGHT ||
                     csr_index == REG_SUB_PASS);

   // Register writes; any valid write abandons the frame in progress
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      pass_in   = pass_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = clamp_width(csr_wdata);
            REG_IMAGE_HEIGHT: height_in = clamp_height(csr_wdata);
            REG_SUB_PASS:     pass_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Position decode
   assign col_max   = COL_W'(width_ff - WD_W'(1));
   assign ht_row    = ROW_W'(height_ff);
   assign ht_row_p1 = ht_row + ROW_W'(1);
   assign end_px    = (row_ff == ht_row_p1) && (col_ff == '0);

   always_comb begin
      step.inb      = (row_ff < ht_row) && !flush && pixel;
      step.mid_en   = (row_ff != '0) && (row_ff <= ht_row);
      step.top_en   = (row_ff >= ROW_W'(2)) && (row_ff <= ht_row_p1);
      step.col_zero = (col_ff == '0);
      step.emit     = (row_ff >= ROW_W'(2)) || ((row_ff == ROW_W'(1)) && (col_ff != '0));
      step.last_px  = end_px;
   end

   // Raster counters advance per accepted beat
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (cfg_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         priority if (end_px) begin
            col_in = '0;
            row_in = '0;
         end else if (col_ff == col_max) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_width(WIDTH_RESET);
         height_ff <= clamp_height(HEIGHT_RESET);
         pass_ff   <= 1'b1;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         pass_ff   <= pass_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   assign col      = col_ff;
   assign sub_pass = pass_ff;
   assign restart  = cfg_hit;

endmodule

// ===== design/tsw_window.sv =====
// Working stage: 3x3 window shift, deletion decision, sticky frame flag,
// line store write-back and the result register. Depends on tsw_pkg, tsw_if.
module tsw_window #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  tsw_pkg::step_type            step_in,
   input  logic [$clog2(MAX_WIDTH)-1:0] col_in,
   input  logic                         restart,
   input  logic                         sub_pass,
   input  logic                         mid_raw,
   input  logic                         top_raw,
   output logic                         ready,
   output tsw_pkg::ram_wr_type          ram_wr,
   output logic [$clog2(MAX_WIDTH)-1:0] ram_waddr,
   tsw_rsp_if.source                    rsp
);
   import tsw_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic             s1_valid_ff, s1_valid_in;
   step_type         s1_step_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [8:0]       win_ff,      win_in;
   logic             changed_ff,  changed_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_thin_ff, out_removed_ff, out_last_ff, out_any_ff;

   logic       advance;
   logic [2:0] newcol;
   logic [8:0] shifted;
   logic [8:0] view;
   logic       del;
   logic       changed_now;

   // Stage moves on when the result register is free or being drained
   assign advance = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign ready   = !s1_valid_ff || advance;

   // New right column: bit0 top, bit1 middle, bit2 incoming
   assign newcol  = {s1_step_ff.inb, s1_step_ff.mid_en & mid_raw, s1_step_ff.top_en & top_raw};
   assign shifted = {3'b000, win_ff[8:3]};

   always_comb begin
      if (s1_step_ff.col_zero) begin
         view   = shifted;
         win_in = {newcol, 6'b000000};
      end else begin
         win_in = {newcol, win_ff[8:3]};
         view   = win_in;
      end
   end

   assign del         = s1_step_ff.emit && delete_decision(view, sub_pass);
   assign changed_now = changed_ff | del;
   assign changed_in  = changed_now;

   // Line store write-back on leaving the stage
   assign ram_wr.we    = advance;
   assign ram_wr.mid   = s1_step_ff.inb;
   assign ram_wr.upper = mid_raw;
   assign ram_waddr    = s1_col_ff;

   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? s1_step_ff.emit : (rsp.ready ? 1'b0 : out_valid_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         win_ff       <= '0;
         changed_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         priority if (restart) begin
            win_ff     <= '0;
            changed_ff <= 1'b0;
         end else if (advance) begin
            if (s1_step_ff.last_px) begin
               win_ff     <= '0;
               changed_ff <= 1'b0;
            end else begin
               win_ff     <= win_in;
               changed_ff <= changed_in;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_step_ff <= step_in;
         s1_col_ff  <= col_in;
      end
      if (advance) begin
         out_thin_ff    <= view[4] & ~del;
         out_removed_ff <= del;
         out_last_ff    <= s1_step_ff.last_px;
         out_any_ff     <= changed_now;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.thinned_pixel = out_thin_ff;
   assign rsp.removed       = out_removed_ff;
   assign rsp.last          = out_last_ff;
   assign rsp.any_removed   = out_any_ff;

endmodule

// ===== sim/tsw_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the thinning sub-pass window: follows the csr port and both
// streams and predicts every result beat. Depends on tsw_pkg and tsw_if.
module tsw_checker #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   tsw_req_if                        req_mon,
   tsw_rsp_if                        rsp_mon,
   input  logic                      csr_write_en,
   input  logic [1:0]                csr_index,
   input  logic [tsw_pkg::CFG_W-1:0] csr_wdata,
   output int unsigned               error_count,
   output int unsigned               results_due
);
   import tsw_pkg::*;

   typedef struct packed {
      logic thinned;
      logic removed;
      logic last;
      logic any;
   } thin_out_t;

   // shadow registers and scan state
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   logic             pass_reg;
   logic             upper_row  [MAX_WIDTH];
   logic             middle_row [MAX_WIDTH];
   logic [8:0]       window;
   int unsigned      col_pos;
   int unsigned      row_pos;
   logic             frame_del;
   thin_out_t        thinned_due [$];

   initial begin
      error_count = 0;
      results_due = 0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         upper_row[i]  = 1'b0;
         middle_row[i] = 1'b0;
      end
   end

   task automatic report_error(input string msg);
      $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
      if (v < MIN_DIM) return 3;
      if (int'(v) > hi) return hi;
      return v;
   endfunction

   // Zhang-Suen test on a window laid out as bit col*3+row
   function automatic logic zs_delete(input logic [8:0] w, input logic sel);
      logic       n, ne, e, se, s, sw, wst, nw, cond;
      logic [7:0] ring;
      int         total;
      int         flips;
      n   = w[3];
      ne  = w[6];
      e   = w[7];
      se  = w[8];
      s   = w[5];
      sw  = w[2];
      wst = w[1];
      nw  = w[0];
      ring  = {nw, wst, sw, s, se, e, ne, n};
      total = $countones(ring);
      // level changes between ring neighbors, two means one 0-to-1 step
      flips = $countones(ring ^ {ring[0], ring[7:1]});
      if (sel) cond = !e || !s || (!n && !wst);
      else     cond = !n || !wst || (!e && !s);
      return w[4] && total >= 2 && total <= 6 && flips == 2 && cond;
   endfunction

   task automatic clear_scan();
      window    = '0;
      col_pos   = 0;
      row_pos   = 0;
      frame_del = 1'b0;
   endtask

   // advance the scan by one accepted beat, queue the result it releases
   task automatic thin_beat(input logic px, input logic fl);
      int unsigned wd, ht, r, c;
      logic        inb, top, mid, del, emit, at_end;
      logic [2:0]  fresh;
      logic [8:0]  view;
      thin_out_t   res;
      wd = clamp_dim(width_reg, MAX_WIDTH);
      ht = clamp_dim(height_reg, MAX_HEIGHT);
      r  = row_pos;
      c  = col_pos;
      if (c >= wd) c = 0;
      inb = (r < ht && !fl) ? px : 1'b0;
      mid = (r >= 1 && r - 1 < ht) ? middle_row[c] : 1'b0;
      top = (r >= 2 && r - 2 < ht) ? upper_row[c] : 1'b0;
      fresh = {inb, mid, top};
      upper_row[c]  = middle_row[c];
      middle_row[c] = inb;

      // row start: the result still belongs to the old row's last centre
      if (c == 0) begin
         view   = {3'b000, window[8:3]};
         window = {fresh, 6'b000000};
      end else begin
         window = {fresh, window[8:3]};
         view   = window;
      end

      emit   = (r >= 2) || (r == 1 && c >= 1);
      at_end = (r == ht + 1) && (c == 0);
      if (c + 1 >= wd) begin
         col_pos = 0;
         row_pos = r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end

      if (emit) begin
         del = zs_delete(view, pass_reg);
         frame_del = frame_del | del;
         res.thinned = view[4] & ~del;
         res.removed = del;
         res.last    = at_end;
         res.any     = frame_del;
         thinned_due.push_back(res);
         if (at_end) clear_scan();
      end
   endtask

   always @(posedge clock) begin
      thin_out_t want;
      if (reset) begin
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         pass_reg   = 1'b1;
         clear_scan();
         thinned_due.delete();
      end else begin
         // a register write abandons the frame in progress
         if (csr_write_en) begin
            case (csr_index)
               REG_IMAGE_WIDTH: begin
                  width_reg = csr_wdata;
                  clear_scan();
               end
               REG_IMAGE_HEIGHT: begin
                  height_reg = csr_wdata;
                  clear_scan();
               end
               REG_SUB_PASS: begin
                  pass_reg = csr_wdata[0];
                  clear_scan();
               end
               default: ;
            endcase
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (thinned_due.size() == 0) begin
               report_error("result beat with no result due");
            end else begin
               want = thinned_due.pop_front();
               if (rsp_mon.thinned_pixel !== want.thinned)
                  report_error($sformatf("thinned_pixel is %b, predicted %b",
                                         rsp_mon.thinned_pixel, want.thinned));
               if (rsp_mon.removed !== want.removed)
                  report_error($sformatf("removed is %b, predicted %b",
                                         rsp_mon.removed, want.removed));
               if (rsp_mon.last !== want.last)
                  report_error($sformatf("last is %b, predicted %b",
                                         rsp_mon.last, want.last));
               if (rsp_mon.any_removed !== want.any)
                  report_error($sformatf("any_removed is %b, predicted %b",
                                         rsp_mon.any_removed, want.any));
            end
         end

         if (req_mon.valid && req_mon.ready) thin_beat(req_mon.pixel, req_mon.flush);
      end
      results_due = thinned_due.size();
   end

endmodule

// ===== sim/thinning_subpass_window_tb.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the thinning sub-pass window: frames of random
// shapes under bursty traffic. Depends on tsw_pkg, tsw_if and tsw_checker.
module thinning_subpass_window_tb;
   import tsw_pkg::*;

   localparam int IDLE_LIMIT    = 4000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 280;
   localparam int RANDOM_PHASES = 5;

   logic             clock;
   logic             reset;
   logic             csr_write_en;
   logic [1:0]       csr_index;
   logic [CFG_W-1:0] csr_wdata;
   int unsigned      error_count;
   int unsigned      results_due;
   int unsigned      burst_left;
   int unsigned      random_sent;
   int unsigned      idle_cycles = 0;
   logic             hold_start  = 1'b0;

   // frame shape: random fill or a box with a little noise
   logic        box_style;
   int unsigned fill_pct;
   int unsigned box_r0, box_r1, box_c0, box_c1;

   tsw_req_if req_bus ();
   tsw_rsp_if rsp_bus ();

   thinning_subpass_window i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   tsw_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .error_count  (error_count),
      .results_due  (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: stretches of different stall patterns, plus a long hold-off on request
   initial begin
      int unsigned mode, stretch;
      rsp_bus.ready = 1'b0;
      forever begin
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(20, 200);
         for (int unsigned k = 0; k < stretch; k++) begin
            @(negedge clock);
            if (hold_start) begin
               rsp_bus.ready <= 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
               hold_start = 1'b0;
            end else begin
               case (mode)
                  0: rsp_bus.ready <= 1'b1;
                  1: rsp_bus.ready <= ($urandom_range(0, 99) < 70);
                  2: rsp_bus.ready <= (k % 5 != 4);
                  default: rsp_bus.ready <= ($urandom_range(0, 99) < 30);
               endcase
            end
         end
      end
   end

   // one request beat; called and returns at a falling edge
   task automatic push_pixel(input logic px, input logic fl);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            req_bus.pixel <= $urandom_range(0, 1);
            req_bus.flush <= $urandom_range(0, 1);
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.pixel <= px;
      req_bus.flush <= fl;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
   endtask

   // all results in, then let beats that release none leave the pipeline
   task automatic settle();
      while (results_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw,
                            input logic sel_pass);
      csr_write_en <= 1'b1;
      csr_index    <= REG_IMAGE_WIDTH;
      csr_wdata    <= w_raw;
      @(negedge clock);
      csr_index    <= REG_IMAGE_HEIGHT;
      csr_wdata    <= h_raw;
      @(negedge clock);
      // upper bits of the sub-pass write are don't-care
      csr_index    <= REG_SUB_PASS;
      csr_wdata    <= {12'($urandom_range(0, 4095)), sel_pass};
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic shape_pixel(input int unsigned r, input int unsigned c);
      if (box_style) begin
         if (r >= box_r0 && r <= box_r1 && c >= box_c0 && c <= box_c1)
            return ($urandom_range(0, 99) >= 5);
         return ($urandom_range(0, 99) < 3);
      end
      return ($urandom_range(0, 99) < fill_pct);
   endfunction

   // raster frame of w x h plus w+1 drain beats; stops after cut beats,
   // optionally waits for every result at beat pause_at
   task automatic send_frame(input int unsigned w, input int unsigned h, input bit noisy,
                             input int unsigned cut, input int unsigned pause_at);
      int unsigned sent;
      sent      = 0;
      box_style = $urandom_range(0, 1);
      fill_pct  = $urandom_range(15, 85);
      box_r0    = $urandom_range(0, h - 1);
      box_r1    = $urandom_range(box_r0, h - 1);
      box_c0    = $urandom_range(0, w - 1);
      box_c1    = $urandom_range(box_c0, w - 1);
      for (int unsigned r = 0; r < h + 2; r++) begin
         for (int unsigned c = 0; c < w; c++) begin
            if (sent == cut) return;
            if (r == h + 1 && c == 1) return;
            if (pause_at != 0 && sent == pause_at) begin
               stop_sending();
               while (results_due != 0) @(negedge clock);
            end
            if (r < h) begin
               // noise: flush beats inside the image
               if (noisy && $urandom_range(0, 19) == 0) push_pixel($urandom_range(0, 1), 1'b1);
               else push_pixel(shape_pixel(r, c), 1'b0);
            end else begin
               // drain beats, some of them plain pixels past the frame end
               if (noisy && $urandom_range(0, 3) == 0) push_pixel($urandom_range(0, 1), 1'b0);
               else push_pixel($urandom_range(0, 1), 1'b1);
            end
            sent++;
         end
      end
   endtask

   initial begin
      int unsigned      w, h, phase, frames, cut, pause_at;
      logic [CFG_W-1:0] w_raw, h_raw;
      logic             sel_pass;
      req_bus.valid = 1'b0;
      req_bus.pixel = 1'b0;
      req_bus.flush = 1'b0;
      csr_write_en  = 1'b0;
      csr_index     = REG_IMAGE_WIDTH;
      csr_wdata     = '0;
      reset         = 1'b1;
      burst_left    = 0;
      random_sent   = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset geometry 640 x 480, start of the first row only
      send_frame(640, 480, 1'b0, 40, 0);
      stop_sending();
      settle();

      // directed: under-range sizes clamp to 3 x 3, solid square
      configure(13'd0, 13'd2, 1'b1);
      repeat (9) push_pixel(1'b1, 1'b0);
      push_pixel(1'b1, 1'b0);
      push_pixel(1'b1, 1'b0);
      push_pixel(1'b0, 1'b1);
      push_pixel(1'b1, 1'b1);
      stop_sending();
      settle();

      // directed: other sub-pass, flush beat in the image centre
      configure(13'd3, 13'd3, 1'b0);
      push_pixel(1'b0, 1'b0);
      push_pixel(1'b1, 1'b0);
      push_pixel(1'b0, 1'b0);
      push_pixel(1'b1, 1'b0);
      push_pixel(1'b1, 1'b1);
      push_pixel(1'b1, 1'b0);
      push_pixel(1'b0, 1'b0);
      push_pixel(1'b1, 1'b0);
      push_pixel(1'b1, 1'b0);
      repeat (4) push_pixel(1'b0, 1'b1);
      stop_sending();
      settle();

      // widest rows: over-range values clamp to the maximum, start of the first row
      configure(13'd8191, 13'd8191, 1'b1);
      send_frame(4096, 4096, 1'b1, 40, 0);
      stop_sending();
      settle();

      // tallest frame at minimum width, first rows
      configure(13'd2, 13'd4096, 1'b0);
      send_frame(3, 4096, 1'b0, 60, 0);
      stop_sending();
      settle();

      // random geometries, mostly small
      phase = 0;
      while (random_sent < RANDOM_ITEMS || phase < RANDOM_PHASES) begin
         if ($urandom_range(0, 7) == 0) w = $urandom_range(11, 40);
         else w = $urandom_range(3, 10);
         h = $urandom_range(3, 8);
         w_raw = w;
         h_raw = h;
         if (w == 3 && $urandom_range(0, 1)) w_raw = $urandom_range(0, 2);
         if (h == 3 && $urandom_range(0, 1)) h_raw = $urandom_range(0, 2);
         sel_pass = $urandom_range(0, 1);
         configure(w_raw, h_raw, sel_pass);
         frames = $urandom_range(1, 2);
         for (int unsigned f = 0; f < frames; f++) begin
            cut = w * h + w + 1;
            if (phase != 2 && phase != 4 && f == frames - 1 && $urandom_range(0, 5) == 0)
               cut = $urandom_range(1, cut - 1);
            pause_at = (phase == 4 && f == 0) ? w * h / 2 : 0;
            // long result-side hold-off while requests keep coming
            if (phase == 2 && f == 0) hold_start = 1'b1;
            send_frame(w, h, $urandom_range(0, 4) == 0, cut, pause_at);
            random_sent += cut;
         end
         stop_sending();
         settle();
         phase++;
      end

      while (results_due != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      if (error_count == 0 && results_due == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
